// ----- hw/rtl/b64e_pkg.sv -----
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types and constants of the streaming Base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  // Register map, indexed by word address.
  localparam logic RegUrlAlphabet = 1'b0;
  localparam logic RegPadEnable   = 1'b1;

  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned MaxChars   = 4;

  // One byte's worth of output characters, decided by the front end.
  typedef struct packed {
    logic [MaxChars-1:0][5:0] sym;      // six-bit groups, slot 0 first
    logic [MaxChars-1:0]      pad;      // slot carries '=' instead of a group
    logic [1:0]               last_idx; // index of the last slot in use
    logic                     fin;      // byte closed the message
  } job_t;

endpackage

// ----- hw/rtl/base64_stream_encoder_top.sv -----
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Streaming Base64 encoder: bytes in, ASCII characters out.
//
//   Channel  Direction  Handshake                  Word
//   input    in         in_valid_i / in_ready_o    data_byte_i, final_byte_i
//   output   out        out_valid_o / out_ready_i  out_char_o, run_last_o,
//                                                  message_end_o
//   config   in         psel/penable/pwrite/pready url_alphabet, pad_enable
//
// The back end emits one character per cycle while the output is not stalled;
// a word produces one or two characters in mid-message, up to four on the final.
// Each word is queued first; its characters then go to the output register.
// Input words are taken while the job queue has room, even while the output
// stalls. Reset clears the group position, the queue and the output valid.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top #(
  parameter int unsigned QueueDepth = b64e_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       final_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [6:0]                 out_char_o,
  output logic                       run_last_o,
  output logic                       message_end_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [b64e_pkg::AddrW-1:0] paddr,
  input  logic [b64e_pkg::DataW-1:0] pwdata,
  output logic [b64e_pkg::DataW-1:0] prdata,
  output logic                       pready
);

  logic           url_q, pad_q;
  logic           cfg_we, accept, full, head_valid, pop;
  b64e_pkg::job_t job, head;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_q <= 1'b0;
      pad_q <= 1'b1;
    end else if (cfg_we) begin
      case (paddr[2])
        b64e_pkg::RegUrlAlphabet: url_q <= pwdata[0];
        b64e_pkg::RegPadEnable:   pad_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      b64e_pkg::RegUrlAlphabet: prdata[0] = url_q;
      b64e_pkg::RegPadEnable:   prdata[0] = pad_q;
      default:                  prdata    = '0;
    endcase
  end

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .pad_enable_i (pad_q),
    .job_o        (job)
  );

  b64e_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .push_data_i  (job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  b64e_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .url_alphabet_i (url_q),
    .out_char_o     (out_char_o),
    .run_last_o     (run_last_o),
    .message_end_o  (message_end_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

  a_ready_tracks_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> head_valid)
    else $error("input stalled with an empty job queue");

endmodule

// ----- hw/rtl/b64e_front.sv -----
// ----------------------------------------------------------------------------
// b64e_front
// Splits each input byte into six-bit groups and builds the character job.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     data_byte_i,
  input  logic           final_byte_i,
  input  logic           pad_enable_i,
  output b64e_pkg::job_t job_o
);

  logic [1:0] phase_q, phase_d;
  logic [3:0] left_q, left_d;

  always_comb begin
    job_o          = '0;
    phase_d        = phase_q;
    left_d         = left_q;
    case (phase_q)
      2'd1: begin
        job_o.sym[0] = {left_q[1:0], data_byte_i[7:4]};
        phase_d      = 2'd2;
        left_d       = data_byte_i[3:0];
        if (final_byte_i) begin
          job_o.sym[1] = {data_byte_i[3:0], 2'b00};
          if (pad_enable_i) begin
            job_o.pad[2]   = 1'b1;
            job_o.last_idx = 2'd2;
          end else begin
            job_o.last_idx = 2'd1;
          end
        end
      end
      2'd2: begin
        job_o.sym[0]   = {left_q, data_byte_i[7:6]};
        job_o.sym[1]   = data_byte_i[5:0];
        job_o.last_idx = 2'd1;
        phase_d        = 2'd0;
        left_d         = 4'd0;
      end
      default: begin
        // Group start; an unused phase code behaves the same way.
        job_o.sym[0] = data_byte_i[7:2];
        phase_d      = 2'd1;
        left_d       = {2'b00, data_byte_i[1:0]};
        if (final_byte_i) begin
          job_o.sym[1] = {data_byte_i[1:0], 4'b0000};
          if (pad_enable_i) begin
            job_o.pad[2]   = 1'b1;
            job_o.pad[3]   = 1'b1;
            job_o.last_idx = 2'd3;
          end else begin
            job_o.last_idx = 2'd1;
          end
        end
      end
    endcase
    job_o.fin = final_byte_i;
    if (final_byte_i) begin
      phase_d = 2'd0;
      left_d  = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      left_q  <= 4'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("group phase left its range");

endmodule

// ----- hw/rtl/b64e_fifo.sv -----
// ----------------------------------------------------------------------------
// b64e_fifo
// Short job queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
module b64e_fifo #(
  parameter int unsigned Depth = b64e_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64e_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output b64e_pkg::job_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64e_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= bump(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= bump(rptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("job queue count exceeds its depth");

  a_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !do_pop |=> full_o)
    else $error("full job queue lost an entry without a pop");

endmodule

// ----- hw/rtl/b64e_back.sv -----
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head job one character per cycle, unless the output stalls, into the output register.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  b64e_pkg::job_t head_i,
  output logic           pop_o,
  input  logic           url_alphabet_i,
  output logic [6:0]     out_char_o,
  output logic           run_last_o,
  output logic           message_end_o,
  output logic           out_valid_o,
  input  logic           out_ready_i
);

  localparam logic [6:0] CharPad   = 7'h3d;
  localparam logic [6:0] CharPlus  = 7'h2b;
  localparam logic [6:0] CharSlash = 7'h2f;
  localparam logic [6:0] CharMinus = 7'h2d;
  localparam logic [6:0] CharUnder = 7'h5f;

  function automatic logic [6:0] enc(logic [5:0] s, logic url);
    logic [6:0] c;
    case (s) inside
      [6'd0:6'd25]:  c = {1'b0, s} + 7'h41;
      [6'd26:6'd51]: c = {1'b0, s} + 7'd71;
      [6'd52:6'd61]: c = {1'b0, s} - 7'd4;
      6'd62:         c = url ? CharMinus : CharPlus;
      default:       c = url ? CharUnder : CharSlash;
    endcase
    return c;
  endfunction

  logic [1:0] idx_q, idx_d;
  logic       oval_q, oval_d;
  logic [6:0] char_q, char_d;
  logic       rlast_q, rlast_d;
  logic       mend_q, mend_d;
  logic       load, is_last;

  assign load    = head_valid_i && (!oval_q || out_ready_i);
  assign is_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d   = idx_q;
    oval_d  = oval_q && !out_ready_i;
    char_d  = char_q;
    rlast_d = rlast_q;
    mend_d  = mend_q;
    if (load) begin
      oval_d  = 1'b1;
      char_d  = head_i.pad[idx_q] ? CharPad : enc(head_i.sym[idx_q], url_alphabet_i);
      rlast_d = is_last;
      mend_d  = is_last && head_i.fin;
      idx_d   = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= 2'd0;
      oval_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q  <= char_d;
    rlast_q <= rlast_d;
    mend_q  <= mend_d;
  end

  assign out_char_o    = char_q;
  assign run_last_o    = rlast_q;
  assign message_end_o = mend_q;
  assign out_valid_o   = oval_q;

  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_end_o |-> run_last_o)
    else $error("message end without run end");

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q <= head_i.last_idx)
    else $error("character index ran past the job");

endmodule

// ----- dv/base64_stream_encoder_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_top_tb
// Self-checking bench for the streaming Base64 encoder. Message bytes go in
// through a queue-fed driver with random gaps. Each accepted word is encoded
// by a local model that tracks the group position, the leftover bits and the
// two registers. A monitor checks every character word against the oldest
// expected one. Register writes happen only when the encoder is drained.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top_tb;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseBytes = 55;

  localparam logic [6:0] ChUpperA     = 7'h41;
  localparam logic [6:0] ChLowerA     = 7'h61;
  localparam logic [6:0] ChDigit0     = 7'h30;
  localparam logic [6:0] ChPlus       = 7'h2b;
  localparam logic [6:0] ChSlash      = 7'h2f;
  localparam logic [6:0] ChMinus      = 7'h2d;
  localparam logic [6:0] ChUnderscore = 7'h5f;
  localparam logic [6:0] ChPad        = 7'h3d;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } byte_word_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       run_last;
    logic       msg_end;
  } char_word_t;

  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_ready_o;
  logic [7:0]                 data_byte_i  = 8'h00;
  logic                       final_byte_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i  = 1'b0;
  logic [6:0]                 out_char_o;
  logic                       run_last_o;
  logic                       message_end_o;
  logic                       psel         = 1'b0;
  logic                       penable      = 1'b0;
  logic                       pwrite       = 1'b0;
  logic [b64e_pkg::AddrW-1:0] paddr        = '0;
  logic [b64e_pkg::DataW-1:0] pwdata       = '0;
  logic [b64e_pkg::DataW-1:0] prdata;
  logic                       pready;

  // Local copy of the encoder state and registers.
  logic       cfg_url   = 1'b0;
  logic       cfg_pad   = 1'b1;
  logic [1:0] grp_phase = 2'd0;
  logic [3:0] carry     = 4'd0;

  byte_word_t  bytes_pending_q[$];
  char_word_t  chars_due_q[$];
  char_word_t  due;
  int unsigned n_queued     = 0;
  int unsigned n_taken      = 0;
  int unsigned n_err        = 0;
  int unsigned n_shown      = 0;
  int unsigned stall_cycles = 0;
  int unsigned rx_hold_left = 0;
  logic        byte_taken   = 1'b0;
  logic        no_idle      = 1'b0;
  logic        rx_hold_req  = 1'b0;

  base64_stream_encoder_top u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [6:0] b64_char(input logic [5:0] six);
    if (six < 6'd26) return ChUpperA + 7'(six);
    if (six < 6'd52) return ChLowerA + 7'(six - 6'd26);
    if (six < 6'd62) return ChDigit0 + 7'(six - 6'd52);
    if (six == 6'd62) return cfg_url ? ChMinus : ChPlus;
    return cfg_url ? ChUnderscore : ChSlash;
  endfunction

  // Advances the local encoder by one byte and queues the characters it emits.
  task automatic encode_byte(input logic [7:0] b, input logic fin);
    logic [6:0] run [4];
    int n;
    char_word_t cw;
    n = 0;
    if (grp_phase == 2'd1) begin
      run[0] = b64_char({carry[1:0], b[7:4]});
      n = 1;
      carry = b[3:0];
      grp_phase = 2'd2;
      if (fin) begin
        run[1] = b64_char({b[3:0], 2'b00});
        n = 2;
        if (cfg_pad) begin
          run[2] = ChPad;
          n = 3;
        end
      end
    end else if (grp_phase == 2'd2) begin
      run[0] = b64_char({carry, b[7:6]});
      run[1] = b64_char(b[5:0]);
      n = 2;
      carry = 4'd0;
      grp_phase = 2'd0;
    end else begin
      // Group start; the unused phase encoding behaves the same way and any
      // stale leftover bits are ignored.
      run[0] = b64_char(b[7:2]);
      n = 1;
      carry = {2'b00, b[1:0]};
      grp_phase = 2'd1;
      if (fin) begin
        run[1] = b64_char({b[1:0], 4'b0000});
        n = 2;
        if (cfg_pad) begin
          run[2] = ChPad;
          run[3] = ChPad;
          n = 4;
        end
      end
    end
    if (fin) begin
      grp_phase = 2'd0;
      carry = 4'd0;
    end
    for (int i = 0; i < n; i++) begin
      cw = {run[i], i == n - 1, fin && (i == n - 1)};
      chars_due_q.insert(chars_due_q.size(), cw);
    end
  endtask

  task automatic queue_byte(input logic [7:0] data, input logic fin);
    byte_word_t w;
    w = {data, fin};
    bytes_pending_q.insert(bytes_pending_q.size(), w);
    n_queued++;
  endtask

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Returns at a falling edge once every word is in and every character out.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (n_taken != n_queued || chars_due_q.size() != 0);
  endtask

  task automatic apb_write(input logic reg_idx, input logic val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= b64e_pkg::DataW'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_idx)
      b64e_pkg::RegUrlAlphabet: cfg_url = val;
      b64e_pkg::RegPadEnable:   cfg_pad = val;
      default: ;
    endcase
  endtask

  // Input driver: a new word is offered only once the current one is taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || byte_taken)) begin
      if (bytes_pending_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 10)) begin
        in_valid_i   <= 1'b1;
        data_byte_i  <= bytes_pending_q[0].data;
        final_byte_i <= bytes_pending_q[0].fin;
        void'(bytes_pending_q.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output receiver with random stalls and an occasional long hold-off.
  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_left = HoldCycles;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle || ($urandom_range(0, 99) >= 10);
    end
  end

  // Prediction of accepted input words, then checking of output words.
  always @(posedge clk_i) begin
    byte_taken = rst_ni && in_valid_i && in_ready_o;
    if (byte_taken) begin
      encode_byte(data_byte_i, final_byte_i);
      n_taken++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (chars_due_q.size() == 0) begin
        n_err++;
        if (n_shown < 10) begin
          n_shown++;
          $display("unexpected char word %h/%b/%b", out_char_o, run_last_o, message_end_o);
        end
      end else begin
        due = chars_due_q.pop_front();
        if (due.ch !== out_char_o || due.run_last !== run_last_o ||
            due.msg_end !== message_end_o) begin
          n_err++;
          if (n_shown < 10) begin
            n_shown++;
            $display("char mismatch: expected %h/%b/%b, got %h/%b/%b",
                     due.ch, due.run_last, due.msg_end,
                     out_char_o, run_last_o, message_end_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))) begin
      stall_cycles++;
    end else begin
      stall_cycles = 0;
    end
    if (stall_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int msg_left;
    logic [1:0] cfg_pick;
    msg_left = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single-byte, two-byte, three-byte and four-byte messages with padding,
    // the extreme byte values and both top alphabet entries.
    wait_idle();
    apb_write(b64e_pkg::RegUrlAlphabet, 1'b0);
    apb_write(b64e_pkg::RegPadEnable, 1'b1);
    @(posedge clk_i);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hff, 1'b1);
    queue_byte(8'hfb, 1'b0);
    queue_byte(8'hff, 1'b1);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'hff, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);

    // URL alphabet without padding, ending mid-message.
    wait_idle();
    apb_write(b64e_pkg::RegUrlAlphabet, 1'b1);
    apb_write(b64e_pkg::RegPadEnable, 1'b0);
    @(posedge clk_i);
    queue_byte(8'hff, 1'b1);
    queue_byte(8'hfb, 1'b0);
    queue_byte(8'hef, 1'b1);
    queue_byte(8'hf8, 1'b0);

    // Alphabet switched while a group is half done.
    wait_idle();
    apb_write(b64e_pkg::RegUrlAlphabet, 1'b0);
    @(posedge clk_i);
    queue_byte(8'h3e, 1'b0);
    queue_byte(8'hff, 1'b1);

    // Random messages; phases may split a message so registers change mid-way.
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      cfg_pick = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
      apb_write(b64e_pkg::RegUrlAlphabet, cfg_pick[0]);
      apb_write(b64e_pkg::RegPadEnable, cfg_pick[1]);
      @(posedge clk_i);
      no_idle = (ph == 3);
      for (int k = 0; k < PhaseBytes; k++) begin
        if (msg_left == 0) begin
          msg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24)
                                                 : $urandom_range(1, 6);
        end
        msg_left--;
        queue_byte(rand_data(), msg_left == 0);
      end
      // The receiver holds off while the sender keeps offering words.
      if (ph == 5) rx_hold_req = 1'b1;
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    n_err += chars_due_q.size();
    if (n_err == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_fifo.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_stream_encoder_top.sv
dv/base64_stream_encoder_top_tb.sv
